FILE: rtl/core/bdel_pkg.sv
package bdel_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_SEARCH     = 3'd4,
    FN_REMOVE     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_APPEND,
    CELL_SHIFT_L,
    CELL_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } cell_data_t;

endpackage

FILE: rtl/core/bdel_in_if.sv
interface bdel_in_if;
  import bdel_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [2:0]                func;
  logic signed [VALUE_W-1:0] value_in;

  modport source (output valid, output func, output value_in, input ready);
  modport sink (input valid, input func, input value_in, output ready);
endinterface

FILE: rtl/core/bdel_out_if.sv
interface bdel_out_if #(
  parameter int COUNT_W = 5
);
  import bdel_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic                      found;
  logic [1:0]                status;
  logic [COUNT_W-1:0]        entry_count;

  modport source (output valid, output value_out, output found, output status,
                  output entry_count, input ready);
  modport sink (input valid, input value_out, input found, input status,
                input entry_count, output ready);
endinterface

FILE: rtl/core/bdel_cell.sv
module bdel_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  bdel_pkg::cell_cmd_t            cmd,
  input  logic signed [bdel_pkg::VALUE_W-1:0] new_value,
  input  logic signed [bdel_pkg::VALUE_W-1:0] head_value,
  input  bdel_pkg::cell_data_t           left,
  input  bdel_pkg::cell_data_t           right,
  output bdel_pkg::cell_data_t           data
);
  import bdel_pkg::*;

  cell_data_t data_next;

  always_comb begin
    data_next = data;
    case (cmd)
      CELL_SHIFT_R: data_next = left;
      CELL_SHIFT_L: data_next = right;
      CELL_APPEND: begin
        if (!data.valid && left.valid) begin
          data_next.valid = 1'b1;
          data_next.value = new_value;
        end
      end
      CELL_ROTATE: begin
        // valid entries circulate toward the front; the head value wraps around to the last valid cell
        if (data.valid) begin
          data_next.value = right.valid ? right.value : head_value;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
    end else begin
      data.valid <= data_next.valid;
    end
    data.value <= data_next.value;
  end

endmodule

FILE: rtl/core/bounded_double_ended_list.sv
// Ordered list of up to CAPACITY signed 32-bit values kept in a row of cells,
// front entry in the first cell, with one result per item (value taken by a
// pop, found flag, status and entry count after the item). Push front, push
// back, pop front, unknown codes, a push into a full list and any item on an
// empty list answer without a scan. Pop back, search and remove on a list
// that holds entries rotate the held entries once around the row past the
// first cell, one step a cycle; a matching entry or the back entry is dropped
// as it passes the first cell, which leaves the order intact. One item is
// worked at a time; a finished result sits in the output register and a new
// item is taken as it leaves. The rsp interface must be built with COUNT_W
// equal to clog2(CAPACITY + 1), which is 5 at the default capacity.
module bounded_double_ended_list #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  bdel_in_if.sink           req,
  bdel_out_if.source        rsp
);
  import bdel_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  state_t                    state;
  state_t                    state_next;
  func_t                     op;
  logic signed [VALUE_W-1:0] key;
  logic [CNT_W-1:0]          step;
  logic [CNT_W-1:0]          scan_len;
  logic                      hit;
  logic [CNT_W-1:0]          held_count;

  logic                      accept;
  logic                      load_rsp;
  logic [CNT_W-1:0]          held_count_next;
  logic                      hit_next;
  logic signed [VALUE_W-1:0] value_out_next;
  logic                      found_next;
  status_t                   status_next;
  cell_cmd_t                 cmd;
  logic                      head_match;
  logic                      last_step;

  cell_data_t                cells [CAPACITY];
  cell_data_t                lefts [CAPACITY];
  cell_data_t                rights [CAPACITY];

  assign req.ready  = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign head_match = cells[0].valid && (cells[0].value == key);
  assign last_step  = (step == scan_len - CNT_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && held_count != '0 &&
            (func_t'(req.func) == FN_POP_BACK || func_t'(req.func) == FN_SEARCH ||
             func_t'(req.func) == FN_REMOVE)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_step) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = CELL_HOLD;
    load_rsp        = 1'b0;
    held_count_next = held_count;
    hit_next        = hit;
    value_out_next  = '0;
    found_next      = 1'b0;
    status_next     = ST_OK;
    case (state)
      S_IDLE: begin
        hit_next = 1'b0;
        if (accept) begin
          case (func_t'(req.func))
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              load_rsp = 1'b1;
              if (held_count == CAP_COUNT) begin
                status_next = ST_FULL;
              end else begin
                cmd = (func_t'(req.func) == FN_PUSH_FRONT) ? CELL_SHIFT_R : CELL_APPEND;
                held_count_next = held_count + CNT_W'(1);
              end
            end
            FN_POP_FRONT: begin
              load_rsp = 1'b1;
              if (held_count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                cmd             = CELL_SHIFT_L;
                value_out_next  = cells[0].value;
                held_count_next = held_count - CNT_W'(1);
              end
            end
            FN_POP_BACK, FN_SEARCH, FN_REMOVE: begin
              if (held_count == '0) begin
                load_rsp    = 1'b1;
                status_next = ST_EMPTY;
              end
            end
            default: load_rsp = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        cmd = CELL_ROTATE;
        case (op)
          FN_POP_BACK: begin
            if (last_step) begin
              cmd             = CELL_SHIFT_L;
              load_rsp        = 1'b1;
              value_out_next  = cells[0].value;
              held_count_next = held_count - CNT_W'(1);
            end
          end
          FN_SEARCH, FN_REMOVE: begin
            if (!hit && head_match) begin
              hit_next = 1'b1;
              if (op == FN_REMOVE) begin
                cmd             = CELL_SHIFT_L;
                held_count_next = held_count - CNT_W'(1);
              end
            end
            if (last_step) begin
              load_rsp    = 1'b1;
              found_next  = hit_next;
              status_next = hit_next ? ST_OK : ST_NOT_FOUND;
            end
          end
          default: begin
            cmd      = CELL_HOLD;
            load_rsp = last_step;
          end
        endcase
      end
      default: cmd = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      hit        <= 1'b0;
      held_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hit        <= hit_next;
      held_count <= held_count_next;
      step       <= (state == S_SCAN) ? step + CNT_W'(1) : '0;
      if (load_rsp) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= func_t'(req.func);
      key      <= req.value_in;
      scan_len <= held_count;
    end
    if (load_rsp) begin
      rsp.value_out   <= value_out_next;
      rsp.found       <= found_next;
      rsp.status      <= status_next;
      rsp.entry_count <= held_count_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{valid: 1'b1, value: req.value_in};
    end else begin : g_mid_left
      assign lefts[i] = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rights[i] = '{valid: 1'b0, value: '0};
    end else begin : g_mid_right
      assign rights[i] = cells[i+1];
    end

    bdel_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_value  (req.value_in),
      .head_value (cells[0].value),
      .left       (lefts[i]),
      .right      (rights[i]),
      .data       (cells[i])
    );
  end

endmodule

FILE: rtl/core/bdel_checker.sv
module bdel_checker #(
  parameter int CAPACITY = 16,
  parameter int COUNT_W  = 5
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [31:0]         value_out,
  input logic                found,
  input logic [1:0]          status,
  input logic [COUNT_W-1:0]  entry_count
);
  import bdel_pkg::*;

  // a transfer waiting on the result side blocks new items
  a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input ready while result is stalled");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value_out) && $stable(found) &&
                                   $stable(status) && $stable(entry_count)))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= COUNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  a_found_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == ST_OK && value_out == '0))
    else $error("found flag with bad status or value");

  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (entry_count == COUNT_W'(CAPACITY) && !found))
    else $error("full status with list not full");

endmodule

bind bounded_double_ended_list bdel_checker #(
  .CAPACITY (CAPACITY),
  .COUNT_W  ($clog2(CAPACITY + 1))
) u_bdel_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .value_out   (rsp.value_out),
  .found       (rsp.found),
  .status      (rsp.status),
  .entry_count (rsp.entry_count)
);

FILE: verif/bounded_double_ended_list_tb.sv
`timescale 1ns / 1ps

module bounded_double_ended_list_tb;
  import bdel_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int COUNT_W       = 5;
  localparam int ITEM_COUNT    = 1000;
  localparam int IDLE_PCT      = 27;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 2 * (CAPACITY + 1) + 8;
  localparam int MAX_REPORTS   = 10;

  localparam logic [2:0] FN_NOP_LO = 3'd6;
  localparam logic [2:0] FN_NOP_HI = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      found;
    status_t                   status;
    logic [COUNT_W-1:0]        entry_count;
  } list_result_t;

  typedef struct {
    logic [2:0]                fn;
    logic signed [VALUE_W-1:0] value;
    int                        reps;
    bit                        fixed;
    list_result_t              want;
  } stim_row_t;

  localparam list_result_t NO_WANT = '0;

  stim_row_t stim_tab [26] = '{
    '{FN_POP_FRONT,  32'sd0,    1, 1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
    '{FN_POP_BACK,   32'sd0,    1, 1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
    '{FN_SEARCH,     32'sd0,    1, 1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
    '{FN_REMOVE,     -32'sd1,   1, 1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
    '{FN_NOP_LO,     VAL_MAX,   1, 1'b1, '{32'sd0, 1'b0, ST_OK, 5'd0}},
    '{FN_PUSH_BACK,  VAL_MIN,   1, 1'b1, '{32'sd0, 1'b0, ST_OK, 5'd1}},
    '{FN_PUSH_FRONT, VAL_MAX,   1, 1'b1, '{32'sd0, 1'b0, ST_OK, 5'd2}},
    '{FN_SEARCH,     32'sd0,    1, 1'b1, '{32'sd0, 1'b0, ST_NOT_FOUND, 5'd2}},
    '{FN_SEARCH,     VAL_MIN,   1, 1'b1, '{32'sd0, 1'b1, ST_OK, 5'd2}},
    '{FN_REMOVE,     VAL_MAX,   1, 1'b1, '{32'sd0, 1'b1, ST_OK, 5'd1}},
    '{FN_POP_FRONT,  32'sd0,    1, 1'b1, '{VAL_MIN, 1'b0, ST_OK, 5'd0}},
    '{FN_PUSH_FRONT, 32'sd0,    1, 1'b1, '{32'sd0, 1'b0, ST_OK, 5'd1}},
    '{FN_POP_BACK,   32'sd0,    1, 1'b1, '{32'sd0, 1'b0, ST_OK, 5'd0}},
    '{FN_PUSH_BACK,  32'sd100, 16, 1'b0, NO_WANT},
    '{FN_PUSH_FRONT, -32'sd5,   1, 1'b1, '{32'sd0, 1'b0, ST_FULL, 5'd16}},
    '{FN_PUSH_BACK,  32'sd7,    1, 1'b1, '{32'sd0, 1'b0, ST_FULL, 5'd16}},
    '{FN_SEARCH,     32'sd999,  1, 1'b1, '{32'sd0, 1'b0, ST_NOT_FOUND, 5'd16}},
    '{FN_NOP_HI,     VAL_MIN,   1, 1'b1, '{32'sd0, 1'b0, ST_OK, 5'd16}},
    '{FN_REMOVE,     32'sd108,  1, 1'b0, NO_WANT},
    '{FN_REMOVE,     32'sd100,  1, 1'b0, NO_WANT},
    '{FN_REMOVE,     32'sd115,  1, 1'b0, NO_WANT},
    '{FN_PUSH_FRONT, 32'sd107,  1, 1'b0, NO_WANT},
    '{FN_REMOVE,     32'sd107,  1, 1'b0, NO_WANT},
    '{FN_SEARCH,     32'sd107,  1, 1'b0, NO_WANT},
    '{FN_POP_BACK,   32'sd0,   13, 1'b0, NO_WANT},
    '{FN_POP_FRONT,  32'sd0,    1, 1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}}
  };

  logic clk;
  logic rst;

  bdel_in_if req_if ();
  bdel_out_if #(.COUNT_W(COUNT_W)) rsp_if ();

  bounded_double_ended_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // per-item tag travels with the request payload
  bit           tag_fixed;
  list_result_t tag_want;

  logic signed [VALUE_W-1:0] held_q [$];
  list_result_t              due_q [$];

  int n_sent       = 0;
  int n_taken      = 0;
  int n_errors     = 0;
  int quiet_cycles = 0;
  int hold_asks    = 0;
  bit calm         = 1'b0;

  function automatic list_result_t list_apply(logic [2:0] fn, logic signed [VALUE_W-1:0] val);
    list_result_t r;
    int           hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (held_q.size() == CAPACITY) r.status = ST_FULL;
        else if (fn == FN_PUSH_FRONT) held_q.push_front(val);
        else held_q.push_back(val);
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (held_q.size() == 0) r.status = ST_EMPTY;
        else if (fn == FN_POP_FRONT) r.value_out = held_q.pop_front();
        else r.value_out = held_q.pop_back();
      end
      FN_SEARCH, FN_REMOVE: begin
        if (held_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < held_q.size(); i++)
            if (hit < 0 && held_q[i] == val) hit = i;
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.found = 1'b1;
            if (fn == FN_REMOVE) held_q.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(held_q.size());
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result check and request tracking
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    list_result_t model;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.value_out, rsp_if.found, status_t'(rsp_if.status), rsp_if.entry_count};
        if (due_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected result: value_out=%0d found=%0b status=%0d count=%0d",
                     got.value_out, got.found, got.status, got.entry_count);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("mismatch: exp value_out=%0d found=%0b status=%0d count=%0d / %s%0d %s%0d %s%0d %s%0d",
                       want.value_out, want.found, want.status, want.entry_count,
                       "act value_out=", got.value_out, "found=", got.found,
                       "status=", got.status, "count=", got.entry_count);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        model = list_apply(req_if.func, req_if.value_in);
        due_q.push_back(tag_fixed ? tag_want : model);
        n_taken++;
      end
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // result side: random stalls, calm stretch, long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic offer(logic [2:0] fn, logic signed [VALUE_W-1:0] val, bit fixed,
                       list_result_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= fn;
    req_if.value_in <= val;
    tag_fixed       <= fixed;
    tag_want        <= want;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    n_sent++;
  endtask

  initial begin
    int                        bias;
    int                        push_pct;
    int                        roll;
    logic [2:0]                fn;
    logic signed [VALUE_W-1:0] val;
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.func     = FN_PUSH_FRONT;
    req_if.value_in = '0;
    tag_fixed       = 1'b0;
    tag_want        = NO_WANT;
    bias            = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(stim_tab); r++)
      for (int j = 0; j < stim_tab[r].reps; j++)
        offer(stim_tab[r].fn, stim_tab[r].value + j, stim_tab[r].fixed, stim_tab[r].want);

    for (int k = 0; k < ITEM_COUNT; k++) begin
      if (k % 40 == 0) bias = $urandom_range(2);
      if (k == 250) hold_asks++;
      if (k == 500) begin
        req_if.valid <= 1'b0;
        wait (n_taken == n_sent && due_q.size() == 0);
      end
      calm = (k >= 600 && k < 800);
      // fill-heavy, drain-heavy or balanced stretches
      push_pct = (bias == 0) ? 60 : (bias == 1) ? 15 : 35;
      roll = $urandom_range(99);
      if (roll < push_pct) fn = $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
      else if (roll < push_pct + 25) fn = $urandom_range(1) ? FN_POP_FRONT : FN_POP_BACK;
      else if (roll < 97) fn = $urandom_range(1) ? FN_SEARCH : FN_REMOVE;
      else fn = $urandom_range(1) ? FN_NOP_LO : FN_NOP_HI;
      // small pool for frequent matches, plus extremes and full range
      roll = $urandom_range(99);
      if (roll < 60) val = $signed(32'($urandom_range(15))) - 32'sd8;
      else if (roll < 70) val = $urandom_range(1) ? VAL_MIN : VAL_MAX;
      else val = $urandom;
      offer(fn, val, 1'b0, NO_WANT);
    end

    req_if.valid <= 1'b0;
    wait (n_taken == n_sent && due_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0 && due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
